// ===== rtl/rars_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the 2-D range add/sum block.
`timescale 1ns / 1ps

package rars_pkg;

  // Default grid bounds
  localparam int ROWS_MAX_DEF = 256;
  localparam int COLS_MAX_DEF = 256;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int COORD_W   = 9;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

  // Item kinds
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Tree numbering
  localparam int NUM_TREES = 4;
  localparam int TREE_PLAIN = 0;  // delta
  localparam int TREE_COLW  = 1;  // col * delta
  localparam int TREE_ROWW  = 2;  // row * delta
  localparam int TREE_BOTH  = 3;  // row * col * delta

  // Shared multiplier operand selection; the product destination follows from the op
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CV,   // w1  = col * v
    MUL_RV,   // w2  = row * v
    MUL_RCV,  // w3  = row * w1
    MUL_RC1,  // prod = (row+1) * (col+1)
    MUL_P0,   // prod = prod * S0
    MUL_P1,   // prod = (row+1) * S1
    MUL_P2    // prod = (col+1) * S2
  } mul_op_e;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_LOAD,  // pre = S3 + prod
    PRE_SUB    // pre = pre - prod
  } pre_op_e;

  typedef struct packed {
    logic       accept;
    logic       clear_wr;
    logic       corner_load;
    logic [1:0] corner;
    mul_op_e    mul_op;
    logic       col_restart;
    logic       row_step;
    logic       node_rd;
    logic       node_wr;
    logic       node_acc;
    logic       col_step;
    pre_op_e    pre_op;
    logic       tot_add;
    logic       out_load;
  } rars_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic row_ok;
    logic col_ok;
    logic out_free;
  } rars_sts_t;

endpackage

// ===== rtl/rars_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rars_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rars_ctrl.sv =====
// Sequencer for clearing, corner tree walks and query result assembly.
`timescale 1ns / 1ps

module rars_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rars_pkg::rars_sts_t sts_i,
  output rars_pkg::rars_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORNER,
    ST_MUL_CV,
    ST_MUL_RV,
    ST_MUL_RCV,
    ST_ROW,
    ST_NODE,
    ST_UPDATE,
    ST_Q_RC,
    ST_Q_P0,
    ST_Q_P1,
    ST_Q_P2,
    ST_Q_PRE,
    ST_NEXT,
    ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.corner = k_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          k_d          = '0;
          state_d      = ST_CORNER;
        end
      end
      ST_CORNER: begin
        cmd_o.corner_load = 1'b1;
        state_d = sts_i.is_query ? ST_ROW : ST_MUL_CV;
      end
      ST_MUL_CV: begin
        cmd_o.mul_op = rars_pkg::MUL_CV;
        state_d      = ST_MUL_RV;
      end
      ST_MUL_RV: begin
        cmd_o.mul_op = rars_pkg::MUL_RV;
        state_d      = ST_MUL_RCV;
      end
      ST_MUL_RCV: begin
        cmd_o.mul_op = rars_pkg::MUL_RCV;
        state_d      = ST_ROW;
      end
      ST_ROW: begin
        if (sts_i.row_ok) begin
          cmd_o.col_restart = 1'b1;
          state_d           = ST_NODE;
        end else begin
          state_d = sts_i.is_query ? ST_Q_RC : ST_NEXT;
        end
      end
      ST_NODE: begin
        if (sts_i.col_ok) begin
          cmd_o.node_rd = 1'b1;
          state_d       = ST_UPDATE;
        end else begin
          cmd_o.row_step = 1'b1;
          state_d        = ST_ROW;
        end
      end
      ST_UPDATE: begin
        cmd_o.node_acc = sts_i.is_query;
        cmd_o.node_wr  = !sts_i.is_query;
        cmd_o.col_step = 1'b1;
        state_d        = ST_NODE;
      end
      ST_Q_RC: begin
        cmd_o.mul_op = rars_pkg::MUL_RC1;
        state_d      = ST_Q_P0;
      end
      ST_Q_P0: begin
        cmd_o.mul_op = rars_pkg::MUL_P0;
        state_d      = ST_Q_P1;
      end
      ST_Q_P1: begin
        cmd_o.pre_op = rars_pkg::PRE_LOAD;
        cmd_o.mul_op = rars_pkg::MUL_P1;
        state_d      = ST_Q_P2;
      end
      ST_Q_P2: begin
        cmd_o.pre_op = rars_pkg::PRE_SUB;
        cmd_o.mul_op = rars_pkg::MUL_P2;
        state_d      = ST_Q_PRE;
      end
      ST_Q_PRE: begin
        cmd_o.pre_op = rars_pkg::PRE_SUB;
        state_d      = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.tot_add = sts_i.is_query;
        if (&k_q) begin
          state_d = sts_i.is_query ? ST_OUT : ST_IDLE;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_CORNER;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rars_dp.sv =====
// Datapath: item registers, tree walk counters, four tree RAMs, shared multiplier, result register.
`timescale 1ns / 1ps

module rars_dp #(
  parameter int ROWS_MAX = rars_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = rars_pkg::COLS_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rars_pkg::rars_cmd_t                cmd_i,
  output rars_pkg::rars_sts_t                sts_o,
  input  logic [rars_pkg::SIZE_W-1:0]        num_rows_i,
  input  logic [rars_pkg::SIZE_W-1:0]        num_cols_i,
  input  logic                               in_action_i,
  input  logic [rars_pkg::COORD_W-1:0]       in_row_a_i,
  input  logic [rars_pkg::COORD_W-1:0]       in_col_a_i,
  input  logic [rars_pkg::COORD_W-1:0]       in_row_b_i,
  input  logic [rars_pkg::COORD_W-1:0]       in_col_b_i,
  input  logic [rars_pkg::DATA_W-1:0]        in_delta_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rars_pkg::DATA_W-1:0]        out_sum_o
);

  localparam int DW    = rars_pkg::DATA_W;
  localparam int IW    = rars_pkg::COORD_W;
  localparam int SW    = rars_pkg::SIZE_W;
  localparam int NT    = rars_pkg::NUM_TREES;
  // walk counters hold up to twice the bound (one step past the end)
  localparam int RW    = $clog2(ROWS_MAX + 1) + 1;
  localparam int CLW   = $clog2(COLS_MAX + 1) + 1;
  localparam int IW2   = (IW > SW) ? IW : SW;
  localparam int CRW   = (RW > IW2) ? RW : IW2;
  localparam int CCW   = (CLW > IW2) ? CLW : IW2;
  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [RW-1:0] clamp_row(input logic [IW-1:0] v);
    logic [CRW-1:0] w;
    w = CRW'(v);
    if (w == '0) w = CRW'(1);
    else if (w > CRW'(ROWS_MAX)) w = CRW'(ROWS_MAX);
    return RW'(w);
  endfunction

  function automatic logic [CLW-1:0] clamp_col(input logic [IW-1:0] v);
    logic [CCW-1:0] w;
    w = CCW'(v);
    if (w == '0) w = CCW'(1);
    else if (w > CCW'(COLS_MAX)) w = CCW'(COLS_MAX);
    return CLW'(w);
  endfunction

  // item registers
  logic           act_q;
  logic [RW-1:0]  r1_q, r2_q;
  logic [CLW-1:0] c1_q, c2_q;
  logic [DW-1:0]  delta_q;

  // walk and arithmetic registers
  logic [RW-1:0]  corner_row_q, row_q;
  logic [CLW-1:0] corner_col_q, col_q;
  logic [DW-1:0]  v_q, w1_q, w2_q, w3_q;
  logic [DW-1:0]  sum_q [NT];
  logic [DW-1:0]  prod_q, pre_q, total_q, out_sum_q;

  // control registers
  logic           out_valid_q;
  logic [AW-1:0]  clr_addr_q;

  // input clamp and corner ordering
  logic [RW-1:0]  ra, rb;
  logic [CLW-1:0] ca, cb;

  always_comb begin
    ra = clamp_row(in_row_a_i);
    rb = clamp_row(in_row_b_i);
    ca = clamp_col(in_col_a_i);
    cb = clamp_col(in_col_b_i);
  end

  // corner selection: rows pick via corner[1], columns via corner[0]
  logic           is_query, corner_neg;
  logic [RW-1:0]  crow;
  logic [CLW-1:0] ccol;

  assign is_query   = (act_q == rars_pkg::ACT_QUERY);
  assign corner_neg = cmd_i.corner[1] ^ cmd_i.corner[0];

  always_comb begin
    if (is_query) begin
      crow = cmd_i.corner[1] ? (r1_q - RW'(1)) : r2_q;
      ccol = cmd_i.corner[0] ? (c1_q - CLW'(1)) : c2_q;
    end else begin
      crow = cmd_i.corner[1] ? (r2_q + RW'(1)) : r1_q;
      ccol = cmd_i.corner[0] ? (c2_q + CLW'(1)) : c1_q;
    end
  end

  // tree walk stepping: updates climb by the low bit, queries descend
  logic [RW-1:0]  row_lsb, row_next;
  logic [CLW-1:0] col_lsb, col_next;
  logic [CRW-1:0] eff_rows;
  logic [CCW-1:0] eff_cols;

  always_comb begin
    row_lsb  = row_q & (-row_q);
    col_lsb  = col_q & (-col_q);
    row_next = is_query ? (row_q - row_lsb) : (row_q + row_lsb);
    col_next = is_query ? (col_q - col_lsb) : (col_q + col_lsb);
    eff_rows = (CRW'(num_rows_i) > CRW'(ROWS_MAX)) ? CRW'(ROWS_MAX) : CRW'(num_rows_i);
    eff_cols = (CCW'(num_cols_i) > CCW'(COLS_MAX)) ? CCW'(COLS_MAX) : CCW'(num_cols_i);
  end

  // node address
  logic [RW-1:0]  row_m1;
  logic [CLW-1:0] col_m1;
  logic [AW-1:0]  node_addr;

  always_comb begin
    row_m1    = row_q - RW'(1);
    col_m1    = col_q - CLW'(1);
    node_addr = AW'(AW'(row_m1) * AW'(COLS_MAX)) + AW'(col_m1);
  end

  // tree RAMs
  logic [DW-1:0] wt        [NT];
  logic [DW-1:0] ram_rdata [NT];
  logic [DW-1:0] ram_wdata [NT];
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  always_comb begin
    wt[rars_pkg::TREE_PLAIN] = v_q;
    wt[rars_pkg::TREE_COLW]  = w1_q;
    wt[rars_pkg::TREE_ROWW]  = w2_q;
    wt[rars_pkg::TREE_BOTH]  = w3_q;
    ram_we    = cmd_i.clear_wr | cmd_i.node_wr;
    ram_waddr = cmd_i.clear_wr ? clr_addr_q : node_addr;
    for (int t = 0; t < NT; t++) begin
      ram_wdata[t] = cmd_i.clear_wr ? '0 : (ram_rdata[t] + wt[t]);
    end
  end

  for (genvar t = 0; t < NT; t++) begin : g_tree
    rars_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(ram_waddr),
      .wdata_i(ram_wdata[t]),
      .re_i   (cmd_i.node_rd),
      .raddr_i(node_addr),
      .rdata_o(ram_rdata[t])
    );
  end

  // shared multiplier, low word kept
  logic [DW-1:0] mul_a, mul_b, mul_res;
  logic [DW-1:0] crow_w, ccol_w;

  always_comb begin
    crow_w = DW'(corner_row_q);
    ccol_w = DW'(corner_col_q);
    case (cmd_i.mul_op)
      rars_pkg::MUL_CV:  begin mul_a = ccol_w;          mul_b = v_q;          end
      rars_pkg::MUL_RV:  begin mul_a = crow_w;          mul_b = v_q;          end
      rars_pkg::MUL_RCV: begin mul_a = crow_w;          mul_b = w1_q;         end
      rars_pkg::MUL_RC1: begin mul_a = crow_w + DW'(1); mul_b = ccol_w + DW'(1); end
      rars_pkg::MUL_P0:  begin mul_a = prod_q;          mul_b = sum_q[rars_pkg::TREE_PLAIN]; end
      rars_pkg::MUL_P1:  begin mul_a = crow_w + DW'(1); mul_b = sum_q[rars_pkg::TREE_COLW]; end
      rars_pkg::MUL_P2:  begin mul_a = ccol_w + DW'(1); mul_b = sum_q[rars_pkg::TREE_ROWW]; end
      default:           begin mul_a = '0;              mul_b = '0;           end
    endcase
    mul_res = mul_a * mul_b;
  end

  // status
  always_comb begin
    sts_o.clear_last = (clr_addr_q == AW'(DEPTH - 1));
    sts_o.is_query   = is_query;
    sts_o.row_ok     = (row_q != '0) && (is_query || (CRW'(row_q) <= eff_rows));
    sts_o.col_ok     = (col_q != '0) && (is_query || (CCW'(col_q) <= eff_cols));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.clear_wr) clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q   <= in_action_i;
      r1_q    <= (ra > rb) ? rb : ra;
      r2_q    <= (ra > rb) ? ra : rb;
      c1_q    <= (ca > cb) ? cb : ca;
      c2_q    <= (ca > cb) ? ca : cb;
      delta_q <= in_delta_i;
      total_q <= '0;
    end
    if (cmd_i.corner_load) begin
      corner_row_q <= crow;
      corner_col_q <= ccol;
      row_q        <= crow;
      col_q        <= ccol;
      v_q          <= corner_neg ? (DW'(0) - delta_q) : delta_q;
      for (int t = 0; t < NT; t++) sum_q[t] <= '0;
    end
    if (cmd_i.col_restart) col_q <= corner_col_q;
    if (cmd_i.col_step)    col_q <= col_next;
    if (cmd_i.row_step)    row_q <= row_next;
    if (cmd_i.node_acc) begin
      for (int t = 0; t < NT; t++) sum_q[t] <= sum_q[t] + ram_rdata[t];
    end
    case (cmd_i.mul_op)
      rars_pkg::MUL_CV:  w1_q <= mul_res;
      rars_pkg::MUL_RV:  w2_q <= mul_res;
      rars_pkg::MUL_RCV: w3_q <= mul_res;
      default: begin
        if (cmd_i.mul_op inside {rars_pkg::MUL_RC1, rars_pkg::MUL_P0,
                                 rars_pkg::MUL_P1, rars_pkg::MUL_P2}) begin
          prod_q <= mul_res;
        end
      end
    endcase
    case (cmd_i.pre_op)
      rars_pkg::PRE_LOAD: pre_q <= sum_q[rars_pkg::TREE_BOTH] + prod_q;
      rars_pkg::PRE_SUB:  pre_q <= pre_q - prod_q;
      default: ;
    endcase
    if (cmd_i.tot_add) total_q <= corner_neg ? (total_q - pre_q) : (total_q + pre_q);
    if (cmd_i.out_load) out_sum_q <= total_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;

endmodule

// ===== rtl/range_add_range_sum_2d.sv =====
// Top level of the 2-D range add / range sum block: ports, config registers, ctrl and datapath.
`timescale 1ns / 1ps
//
// Grid of 32-bit integers held as four 2-D binary indexed trees in four RAMs.
// Input items arrive on s_axis; tuser selects add (0) or query (1). An add
// puts delta on every cell of the rectangle and produces nothing; a query
// produces one item on m_axis holding the wrapped rectangle sum.
// Config writes (index 0 = rows in use, 1 = cols in use, 9 bits each) go on
// the cfg channel, always ready; write them only while the block is idle.
// Timing: one item at a time; s_axis_tready stays low until it is done.
// Each item runs four corners. An add corner first forms its weighted
// deltas; a query corner ends by combining its four tree sums. Each
// corner walks the tree nodes per axis (up to log2(max)+1 each), and
// each node is read and then written or accumulated through the
// registered RAM read port.
// Reset: all four RAMs are cleared by a pass over all ROWS_MAX*COLS_MAX
// addresses, during which s_axis_tready stays low.
// Output stall: the result sits in an output register; the next item is
// accepted meanwhile, and only a following query result waits for room.
//

module range_add_range_sum_2d #(
  parameter int ROWS_MAX = rars_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = rars_pkg::COLS_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [71:0]                       s_axis_tdata,  // row_a, col_a, row_b, col_b, delta, pad
  input  logic                              s_axis_tuser,  // action
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rars_pkg::DATA_W-1:0]       m_axis_tdata,  // rect_sum
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rars_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rars_pkg::SIZE_W-1:0]       cfg_data_i
);

  localparam int IW       = rars_pkg::COORD_W;
  localparam int ROW_A_LO = 0;
  localparam int COL_A_LO = ROW_A_LO + IW;
  localparam int ROW_B_LO = COL_A_LO + IW;
  localparam int COL_B_LO = ROW_B_LO + IW;
  localparam int DELTA_LO = COL_B_LO + IW;

  logic [rars_pkg::SIZE_W-1:0] num_rows_q, num_cols_q;

  rars_pkg::rars_cmd_t cmd;
  rars_pkg::rars_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= rars_pkg::SIZE_RST;
      num_cols_q <= rars_pkg::SIZE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rars_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data_i;
        rars_pkg::REG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  rars_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rars_dp #(
    .ROWS_MAX(ROWS_MAX),
    .COLS_MAX(COLS_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .num_rows_i (num_rows_q),
    .num_cols_i (num_cols_q),
    .in_action_i(s_axis_tuser),
    .in_row_a_i (s_axis_tdata[ROW_A_LO +: IW]),
    .in_col_a_i (s_axis_tdata[COL_A_LO +: IW]),
    .in_row_b_i (s_axis_tdata[ROW_B_LO +: IW]),
    .in_col_b_i (s_axis_tdata[COL_B_LO +: IW]),
    .in_delta_i (s_axis_tdata[DELTA_LO +: rars_pkg::DATA_W]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_sum_o  (m_axis_tdata)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the 2-D range add / range sum block.
`timescale 1ns / 1ps

module tb;
  import rars_pkg::*;

  localparam int ROWS = ROWS_MAX_DEF;
  localparam int COLS = COLS_MAX_DEF;
  // an add may still be running after the last sum came out, so SETTLE_CYCLES
  // of quiet time precede a register write
  localparam int SETTLE_CYCLES = 1000;
  // indexes with no register behind them: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic   act;
    coord_t row_a;
    coord_t col_a;
    coord_t row_b;
    coord_t col_b;
    word_t  delta;
  } grid_op_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [71:0]          s_axis_tdata;   // row_a, col_a, row_b, col_b, delta, pad
  logic                 s_axis_tuser;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;   // rect_sum
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  range_add_range_sum_2d i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Golden grid: same four Fenwick trees, same node layout, 32-bit wrap.
  // ---------------------------------------------------------------------------
  bit [31:0]         fw [NUM_TREES][ROWS*COLS];
  bit [SIZE_W-1:0]   rows_reg = SIZE_RST;
  bit [SIZE_W-1:0]   cols_reg = SIZE_RST;
  word_t             pending_sums[$];

  bit                steady = 1'b0;   // both sides run without idle cycles
  int unsigned       n_adds, n_queries, n_sums, n_mismatch, n_sizes;

  function automatic int unsigned low_bit(int unsigned x);
    return x & (~x + 1);
  endfunction

  // 0 reads as 1, anything above the grid bound as the bound
  function automatic int unsigned fit_coord(coord_t v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned rows_used();
    return (rows_reg > ROWS) ? ROWS : rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    return (cols_reg > COLS) ? COLS : cols_reg;
  endfunction

  // update walks stop at the size in use
  function automatic void tree_bump(int k, int unsigned r, int unsigned c0, bit [31:0] v);
    int unsigned nr, nc, c;
    nr = rows_used();
    nc = cols_used();
    while (r != 0 && r <= nr) begin
      c = c0;
      while (c != 0 && c <= nc) begin
        fw[k][(r-1)*COLS + (c-1)] += v;
        c += low_bit(c);
      end
      r += low_bit(r);
    end
  endfunction

  // prefix walks read whatever is stored, size in use or not
  function automatic bit [31:0] tree_sum(int k, int unsigned r, int unsigned c0);
    bit [31:0]   acc;
    int unsigned c;
    acc = '0;
    while (r != 0) begin
      c = c0;
      while (c != 0) begin
        acc += fw[k][(r-1)*COLS + (c-1)];
        c -= low_bit(c);
      end
      r -= low_bit(r);
    end
    return acc;
  endfunction

  function automatic void point_bump(int unsigned r, int unsigned c, bit [31:0] v);
    bit [31:0] cv, rv, rcv;
    cv  = c * v;
    rv  = r * v;
    rcv = r * cv;
    tree_bump(TREE_PLAIN, r, c, v);
    tree_bump(TREE_COLW, r, c, cv);
    tree_bump(TREE_ROWW, r, c, rv);
    tree_bump(TREE_BOTH, r, c, rcv);
  endfunction

  function automatic bit [31:0] corner_sum(int unsigned r, int unsigned c);
    bit [31:0] r1, c1, s0, s1, s2, s3;
    r1 = r + 1;
    c1 = c + 1;
    s0 = tree_sum(TREE_PLAIN, r, c);
    s1 = tree_sum(TREE_COLW, r, c);
    s2 = tree_sum(TREE_ROWW, r, c);
    s3 = tree_sum(TREE_BOTH, r, c);
    return r1 * c1 * s0 - r1 * s1 - c1 * s2 + s3;
  endfunction

  // apply one accepted item to the golden grid; a query queues its sum
  function automatic void grid_apply(grid_op_t op);
    int unsigned r1, c1, r2, c2, t;
    bit [31:0]   d, nd, s;
    r1 = fit_coord(op.row_a, ROWS);
    c1 = fit_coord(op.col_a, COLS);
    r2 = fit_coord(op.row_b, ROWS);
    c2 = fit_coord(op.col_b, COLS);
    if (r1 > r2) begin
      t = r1; r1 = r2; r2 = t;
    end
    if (c1 > c2) begin
      t = c1; c1 = c2; c2 = t;
    end
    d  = op.delta;
    nd = 32'd0 - d;
    if (op.act == ACT_ADD) begin
      point_bump(r1, c1, d);
      point_bump(r1, c2 + 1, nd);
      point_bump(r2 + 1, c1, nd);
      point_bump(r2 + 1, c2 + 1, d);
      n_adds++;
    end else begin
      s = corner_sum(r2, c2) - corner_sum(r1 - 1, c2)
        - corner_sum(r2, c1 - 1) + corner_sum(r1 - 1, c1 - 1);
      pending_sums.push_back(s);
      n_queries++;
    end
  endfunction

  function automatic void reg_apply(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    if (idx == REG_NUM_ROWS) rows_reg = data;
    else if (idx == REG_NUM_COLS) cols_reg = data;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // the timeout lies several times beyond the slowest legal run
  initial begin
    #(30_000_000);
    $display("tb: timeout, %0d sums still pending", pending_sums.size());
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall draws land while a sum is waiting; compare in order.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    n_mismatch++;
  endtask

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (stall - 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("rect_sum %h with no query pending", m_axis_tdata));
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("rect_sum #%0d got %h want %h",
                                    n_sums, m_axis_tdata, want));
        n_sums++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item and register drivers
  // ---------------------------------------------------------------------------
  // leaves tvalid high on return so a back-to-back item needs no second
  // assignment in the same step
  task automatic send_item(grid_op_t op);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.act;
    s_axis_tdata  <= {4'b0, op.delta, op.col_b, op.row_b, op.col_a, op.row_a};
    do @(posedge clk_i); while (!s_axis_tready);
    grid_apply(op);
  endtask

  // stop sending until every queued sum has come back
  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_apply(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(int unsigned rows, int unsigned cols);
    settle();
    cfg_write(REG_NUM_ROWS, SIZE_W'(rows));
    cfg_write(REG_NUM_COLS, SIZE_W'(cols));
    n_sizes++;
  endtask

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------
  function automatic grid_op_t mk_op(logic act, int unsigned ra, int unsigned ca,
                                     int unsigned rb, int unsigned cb, word_t d);
    grid_op_t op;
    op.act   = act;
    op.row_a = coord_t'(ra);
    op.col_a = coord_t'(ca);
    op.row_b = coord_t'(rb);
    op.col_b = coord_t'(cb);
    op.delta = d;
    return op;
  endfunction

  // mostly inside the area in use (plus one past it), some raw 9-bit values, zero and the grid bound
  function automatic coord_t pick_coord(int unsigned used, int unsigned hi);
    int unsigned lim;
    lim = used + 1;
    if (lim > hi) lim = hi;
    case ($urandom_range(0, 19))
      0:       return coord_t'($urandom_range(0, 2**COORD_W - 1));
      1:       return '0;
      2:       return coord_t'(hi);
      default: return coord_t'($urandom_range(1, lim));
    endcase
  endfunction

  function automatic word_t pick_delta();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic grid_op_t rand_op();
    grid_op_t op;
    op.act   = ($urandom_range(0, 99) < 45) ? ACT_QUERY : ACT_ADD;
    op.row_a = pick_coord(rows_used(), ROWS);
    op.col_a = pick_coord(cols_used(), COLS);
    op.row_b = pick_coord(rows_used(), ROWS);
    op.col_b = pick_coord(cols_used(), COLS);
    op.delta = pick_delta();
    return op;
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0:             return $urandom_range(0, 2**SIZE_W - 1);
      1:             return ROWS;
      2, 3, 4, 5:    return $urandom_range(1, 32);
      default:       return $urandom_range(1, 256);
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_item(rand_op());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // full 256x256 grid: empty grid, extreme deltas, swapped / zero / oversize
  // corners, single cells, and a query carrying a nonzero delta
  task automatic test_directed_corners();
    send_item(mk_op(ACT_QUERY,   1,   1, 256, 256, 32'h0));
    send_item(mk_op(ACT_ADD,     1,   1, 256, 256, 32'h7fff_ffff));
    send_item(mk_op(ACT_QUERY,   1,   1,   1,   1, 32'h0));
    send_item(mk_op(ACT_QUERY, 256, 256, 256, 256, 32'h0));
    send_item(mk_op(ACT_QUERY,   1,   1, 256, 256, 32'h0));
    send_item(mk_op(ACT_ADD,   200, 190,   3,   7, 32'h8000_0000));
    send_item(mk_op(ACT_QUERY, 256, 256,   1,   1, 32'hdead_beef));
    send_item(mk_op(ACT_ADD,     0,   0,   0,   5, 32'hffff_ffff));
    send_item(mk_op(ACT_ADD,   511, 300, 257, 256, 32'h5));
    send_item(mk_op(ACT_QUERY,   0,   0, 511, 511, 32'h0));
    send_item(mk_op(ACT_ADD,   128, 128, 128, 128, 32'h8000_0000));
    send_item(mk_op(ACT_QUERY, 128, 128, 128, 128, 32'h123));
    send_item(mk_op(ACT_QUERY, 127, 127, 129, 129, 32'h0));
    send_item(mk_op(ACT_ADD,     1, 256, 256,   1, 32'h1));
    send_item(mk_op(ACT_QUERY,   2, 255, 255,   2, 32'h0));
    send_item(mk_op(ACT_QUERY, 256,   1,   1, 256, 32'h0));
    send_item(mk_op(ACT_ADD,     1,   1,   1,   1, 32'h7fff_ffff));
    send_item(mk_op(ACT_QUERY,   0,   1,   1,   0, 32'h0));
    send_item(mk_op(ACT_QUERY, 100,  50,   3, 200, 32'h0));
    send_item(mk_op(ACT_QUERY,   1,   1, 256, 256, 32'h0));
  endtask

  // zero size (adds do nothing), oversize (saturates), single row/column,
  // and writes to the unused indexes
  task automatic test_size_extremes();
    set_grid(0, 0);
    run_random(40);
    set_grid(2**SIZE_W - 1, 2**SIZE_W - 1);
    run_random(40);
    set_grid(1, 1);
    run_random(40);
    set_grid(ROWS, 1);
    run_random(40);
    set_grid(1, COLS);
    run_random(40);
    settle();
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, '0);
    cfg_write(REG_SPARE_B, SIZE_W'($urandom));
    run_random(40);
    set_grid(ROWS, COLS);
  endtask

  // random sizes, often small; three phases without idle cycles on either
  // side, and some phases drain the result queue halfway through
  task automatic test_random_sizes();
    for (int p = 0; p < 18; p++) begin
      set_grid(pick_size(), pick_size());
      steady = (p % 6 == 3);
      run_random(29);
      if (p % 5 == 2) hold_off();
      run_random(29);
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_ADD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_NUM_ROWS;
    cfg_data_i    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first item waits out the RAM clearing pass via tready
    test_directed_corners();
    test_size_extremes();
    test_random_sizes();

    settle();
    $display("tb: %0d adds and %0d queries across %0d grid size settings",
             n_adds, n_queries, n_sizes + 1);
    $display("tb: %0d rectangle sums compared, %0d mismatches", n_sums, n_mismatch);
    if (n_mismatch == 0 && pending_sums.size() == 0) begin
      $display("tb: clean");
    end else begin
      if (pending_sums.size() != 0)
        $display("tb: %0d expected sums never arrived", pending_sums.size());
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rars_pkg.sv
rtl/rars_ram.sv
rtl/rars_ctrl.sv
rtl/rars_dp.sv
rtl/range_add_range_sum_2d.sv
tb/sv/tb.sv
